>>> hw/rtl/bre_pkg.sv
// Shared types and constants for the bitmap range engine.
// No dependencies; every design file imports this package (bre_checker does not).
package bre_pkg;

  localparam int NUM_WORDS  = 64;
  localparam int WORD_BITS  = 64;
  localparam int OFF_W      = $clog2(WORD_BITS);
  localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL_BITS = NUM_WORDS * WORD_BITS;
  localparam int POS_W      = $clog2(TOTAL_BITS + 1);
  localparam int EXT_W      = (POS_W > 14) ? POS_W : 14;
  localparam int ONES_W     = OFF_W + 1;
  localparam int CNT_W      = 13;
  localparam int FIDX_W     = 12;

  typedef enum logic [2:0] {
    ACT_WRITE  = 3'd0,
    ACT_READ   = 3'd1,
    ACT_SET    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_INVERT = 3'd4,
    ACT_COUNT  = 3'd5,
    ACT_FIND   = 3'd6,
    ACT_TEST   = 3'd7
  } action_t;

  typedef struct packed {
    action_t          op;
    logic             lo_en;
    logic             hi_en;
    logic [OFF_W-1:0] a_off;
    logic [OFF_W-1:0] b_off;
  } alu_ctl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic [ONES_W-1:0]    ones;
    logic                 any;
    logic [OFF_W-1:0]     pos;
  } alu_res_t;

endpackage

>>> hw/rtl/bre_store.sv
// Bitmap word store: one write port, one registered read port.
// Per-word valid flags make unwritten words read as zero after reset.
// Depends on bre_pkg.
module bre_store
  import bre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [WIDX_W-1:0]    wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [WIDX_W-1:0]    rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] vld_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

>>> hw/rtl/bre_alu.sv
// Word unit shared by every range command: builds the range mask for one
// word, applies set/clear/invert, counts and locates the masked set bits.
// Depends on bre_pkg.
module bre_alu
  import bre_pkg::*;
(
  input  alu_ctl_t             ctl,
  input  logic [WORD_BITS-1:0] word_in,
  output alu_res_t             res
);

  localparam int BYTES = WORD_BITS / 8;

  function automatic logic [3:0] pop8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] sel;
  logic [ONES_W-1:0]    ones;
  logic [OFF_W-1:0]     pos;

  always_comb begin
    lo_mask = ctl.lo_en ? ({WORD_BITS{1'b1}} << ctl.a_off) : {WORD_BITS{1'b1}};
    hi_mask = ctl.hi_en ? ({WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - ctl.b_off))
                        : {WORD_BITS{1'b1}};
    mask = lo_mask & hi_mask;
    sel  = word_in & mask;

    ones = '0;
    for (int i = 0; i < BYTES; i++) begin
      ones = ones + ONES_W'(pop8(sel[8*i +: 8]));
    end

    // lowest set bit wins
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        pos = OFF_W'(i);
      end
    end

    case (ctl.op) inside
      ACT_SET:    res.new_word = word_in | mask;
      ACT_CLEAR:  res.new_word = word_in & ~mask;
      ACT_INVERT: res.new_word = word_in ^ mask;
      default:    res.new_word = word_in;
    endcase
    res.ones = ones;
    res.any  = |sel;
    res.pos  = pos;
  end

endmodule

>>> hw/rtl/bitmap_range_engine.sv
// Bitmap range engine: 64 words of 64 bits, one command accepted at a time.
// Steps from accept to out_valid: write word writes the store at accept, then passes S_OUT;
// read word and test read one word and pass S_SCAN and S_OUT; range commands scan each word
// they touch in S_SCAN, then pass S_OUT. A new command is taken only back in S_IDLE, after
// the last result is loaded; one word unit and a one-read one-write store visit a word a cycle.
// Reset: synchronous, active low; returns to idle and clears the map at once.
module bitmap_range_engine
  import bre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           in_action,
  input  logic [5:0]           in_word_index,
  input  logic [63:0]          in_word_data,
  input  logic [11:0]          in_range_start,
  input  logic [12:0]          in_range_length,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_read_data,
  output logic [12:0]          out_set_count,
  output logic                 out_found,
  output logic [11:0]          out_found_index,
  output logic                 out_bit_value,
  output logic                 out_out_of_range
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  action_t          act_r, act_nxt;
  logic [WIDX_W-1:0] proc_w_r, proc_w_nxt;
  logic [WIDX_W-1:0] cur_w_r, cur_w_nxt;
  logic [WIDX_W-1:0] first_w_r, first_w_nxt;
  logic [WIDX_W-1:0] last_w_r, last_w_nxt;
  logic              more_r, more_nxt;
  logic [OFF_W-1:0]  a_off_r, a_off_nxt;
  logic [OFF_W-1:0]  b_off_r, b_off_nxt;
  logic [OFF_W-1:0]  bitsel_r, bitsel_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic [FIDX_W-1:0] fidx_r, fidx_nxt;
  logic [63:0]       rdata_r, rdata_nxt;
  logic              bitv_r, bitv_nxt;
  logic              oor_r, oor_nxt;

  logic [63:0]       out_read_data_r;
  logic [CNT_W-1:0]  out_set_count_r;
  logic              out_found_r;
  logic [FIDX_W-1:0] out_found_index_r;
  logic              out_bit_value_r;
  logic              out_oor_r;
  logic              load;

  // store ports
  logic                 wr_en;
  logic [WIDX_W-1:0]    wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic                 rd_en;
  logic [WIDX_W-1:0]    rd_addr;
  logic [WORD_BITS-1:0] rd_data;

  alu_ctl_t alu_ctl;
  alu_res_t alu_res;

  // command decode
  action_t           act_in;
  logic [EXT_W-1:0]  start_x, end_x, total_x, lo_x, hi_x, hi_m1;
  logic              range_oor, nonempty, widx_ok, test_ok;
  logic [WIDX_W-1:0] widx_w, test_w, first_w, last_w;

  always_comb begin
    act_in    = action_t'(in_action);
    start_x   = EXT_W'(in_range_start);
    end_x     = start_x + EXT_W'(in_range_length);
    total_x   = EXT_W'(TOTAL_BITS);
    lo_x      = (start_x < total_x) ? start_x : total_x;
    hi_x      = (end_x < total_x) ? end_x : total_x;
    hi_m1     = hi_x - EXT_W'(1);
    range_oor = end_x > total_x;
    nonempty  = hi_x > lo_x;
    first_w   = lo_x[WIDX_W+OFF_W-1:OFF_W];
    last_w    = hi_m1[WIDX_W+OFF_W-1:OFF_W];
    widx_ok   = EXT_W'(in_word_index) < EXT_W'(NUM_WORDS);
    widx_w    = WIDX_W'(in_word_index);
    test_ok   = start_x < total_x;
    test_w    = start_x[WIDX_W+OFF_W-1:OFF_W];
  end

  always_comb begin
    alu_ctl.op    = act_r;
    alu_ctl.lo_en = proc_w_r == first_w_r;
    alu_ctl.hi_en = proc_w_r == last_w_r;
    alu_ctl.a_off = a_off_r;
    alu_ctl.b_off = b_off_r;
  end

  bre_alu u_alu (
    .ctl     (alu_ctl),
    .word_in (rd_data),
    .res     (alu_res)
  );

  bre_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    proc_w_nxt  = proc_w_r;
    cur_w_nxt   = cur_w_r;
    first_w_nxt = first_w_r;
    last_w_nxt  = last_w_r;
    more_nxt    = more_r;
    a_off_nxt   = a_off_r;
    b_off_nxt   = b_off_r;
    bitsel_nxt  = bitsel_r;
    cnt_nxt     = cnt_r;
    found_nxt   = found_r;
    fidx_nxt    = fidx_r;
    rdata_nxt   = rdata_r;
    bitv_nxt    = bitv_r;
    oor_nxt     = oor_r;
    load        = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = proc_w_r;
    wr_data     = alu_res.new_word;
    rd_en       = 1'b0;
    rd_addr     = cur_w_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt     = act_in;
          cnt_nxt     = '0;
          found_nxt   = 1'b0;
          fidx_nxt    = '0;
          rdata_nxt   = '0;
          bitv_nxt    = 1'b0;
          bitsel_nxt  = in_range_start[OFF_W-1:0];
          a_off_nxt   = lo_x[OFF_W-1:0];
          b_off_nxt   = hi_m1[OFF_W-1:0];
          first_w_nxt = first_w;
          last_w_nxt  = last_w;
          more_nxt    = 1'b0;
          state_nxt   = S_OUT;
          unique case (act_in)
            ACT_WRITE: begin
              oor_nxt = !widx_ok;
              wr_en   = widx_ok;
              wr_addr = widx_w;
              wr_data = in_word_data;
            end
            ACT_READ: begin
              oor_nxt = !widx_ok;
              if (widx_ok) begin
                rd_en      = 1'b1;
                rd_addr    = widx_w;
                proc_w_nxt = widx_w;
                state_nxt  = S_SCAN;
              end
            end
            ACT_TEST: begin
              oor_nxt = !test_ok;
              if (test_ok) begin
                rd_en      = 1'b1;
                rd_addr    = test_w;
                proc_w_nxt = test_w;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              oor_nxt = range_oor;
              if (nonempty) begin
                rd_en      = 1'b1;
                rd_addr    = first_w;
                proc_w_nxt = first_w;
                cur_w_nxt  = first_w + WIDX_W'(1);
                more_nxt   = first_w != last_w;
                state_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds the word at proc_w_r
        case (act_r) inside
          ACT_READ: rdata_nxt = rd_data;
          ACT_TEST: bitv_nxt  = rd_data[bitsel_r];
          ACT_SET, ACT_CLEAR, ACT_INVERT: wr_en = 1'b1;
          ACT_COUNT: cnt_nxt = cnt_r + CNT_W'(alu_res.ones);
          ACT_FIND: begin
            if (!found_r && alu_res.any) begin
              found_nxt = 1'b1;
              fidx_nxt  = FIDX_W'({proc_w_r, alu_res.pos});
            end
          end
          default: ;
        endcase
        // fetch the next word while this one is written back
        if (more_r) begin
          rd_en      = 1'b1;
          rd_addr    = cur_w_r;
          proc_w_nxt = cur_w_r;
          cur_w_nxt  = cur_w_r + WIDX_W'(1);
          more_nxt   = cur_w_r != last_w_r;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = load | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    proc_w_r  <= proc_w_nxt;
    cur_w_r   <= cur_w_nxt;
    first_w_r <= first_w_nxt;
    last_w_r  <= last_w_nxt;
    more_r    <= more_nxt;
    a_off_r   <= a_off_nxt;
    b_off_r   <= b_off_nxt;
    bitsel_r  <= bitsel_nxt;
    cnt_r     <= cnt_nxt;
    found_r   <= found_nxt;
    fidx_r    <= fidx_nxt;
    rdata_r   <= rdata_nxt;
    bitv_r    <= bitv_nxt;
    oor_r     <= oor_nxt;
    if (load) begin
      out_read_data_r   <= rdata_r;
      out_set_count_r   <= cnt_r;
      out_found_r       <= found_r;
      out_found_index_r <= fidx_r;
      out_bit_value_r   <= bitv_r;
      out_oor_r         <= oor_r;
    end
  end

  assign in_ready         = state_r == S_IDLE;
  assign out_valid        = out_valid_r;
  assign out_read_data    = out_read_data_r;
  assign out_set_count    = out_set_count_r;
  assign out_found        = out_found_r;
  assign out_found_index  = out_found_index_r;
  assign out_bit_value    = out_bit_value_r;
  assign out_out_of_range = out_oor_r;

endmodule

>>> hw/rtl/bre_checker.sv
// Port-level checks for bitmap_range_engine, attached by the bind below.
// Depends only on the top level's ports.
module bre_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_read_data,
  input logic [12:0] out_set_count,
  input logic        out_found,
  input logic [11:0] out_found_index,
  input logic        out_bit_value,
  input logic        out_out_of_range
);

  // in_ready low in the cycle after a command is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
      $stable(out_set_count) && $stable(out_found) && $stable(out_found_index) &&
      $stable(out_bit_value) && $stable(out_out_of_range))
    else $error("result changed while stalled");

  a_index_needs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == 12'd0)
    else $error("found_index set without found");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != 64'd0 |->
      out_set_count == 13'd0 && !out_found && !out_bit_value)
    else $error("result carries fields of two commands");

endmodule

bind bitmap_range_engine bre_props u_bre_props (.*);
